### hdl/mcst_pkg.sv
// ----------------------------------------------------------------------------
// mcst_pkg
// Types and constants shared by the multi-channel software timer files.
// ----------------------------------------------------------------------------
`default_nettype none

package mcst_pkg;

  localparam int unsigned TimerCountDef = 8;
  localparam int unsigned MaxNotices    = 8;
  localparam int unsigned NoticeCntW    = $clog2(MaxNotices + 1);

  localparam int unsigned KindW   = 3;
  localparam int unsigned IndexW  = 8;
  localparam int unsigned PeriodW = 32;

  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  typedef enum logic [KindW-1:0] {
    KIND_TICK       = 3'd0,
    KIND_SERVICE    = 3'd1,
    KIND_CREATE     = 3'd2,
    KIND_START      = 3'd3,
    KIND_STOP       = 3'd4,
    KIND_RESTART    = 3'd5,
    KIND_DELETE     = 3'd6,
    KIND_SET_PERIOD = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_EXPIRED = 2'd2
  } mode_e;

  typedef enum logic {
    RES_STATUS = 1'b0,
    RES_NOTICE = 1'b1
  } res_kind_e;

  typedef enum logic {
    REG_DEFERRED = 1'b0
  } reg_index_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_FLUSH,
    S_STATUS
  } state_e;

endpackage

`default_nettype wire

### hdl/mcst_if.sv
// ----------------------------------------------------------------------------
// mcst_in_if / mcst_out_if
// Valid/ready channels for timer commands and for timer results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcst_in_if;
  logic                             valid;
  logic                             ready;
  logic [mcst_pkg::KindW-1:0]       kind;
  logic [mcst_pkg::IndexW-1:0]      timer_index;
  logic [mcst_pkg::PeriodW-1:0]     period_ticks;
  logic                             reload_on_expiry;
  logic                             notify_on_expiry;

  modport source (
    output valid, kind, timer_index, period_ticks, reload_on_expiry, notify_on_expiry,
    input  ready
  );
  modport sink (
    input  valid, kind, timer_index, period_ticks, reload_on_expiry, notify_on_expiry,
    output ready
  );
endinterface

interface mcst_out_if;
  logic                        valid;
  logic                        ready;
  logic                        result_kind;
  logic                        accepted;
  logic [mcst_pkg::IndexW-1:0] slot;
  logic                        last_of_run;

  modport source (
    output valid, result_kind, accepted, slot, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, result_kind, accepted, slot, last_of_run,
    output ready
  );
endinterface

`default_nettype wire

### hdl/multi_channel_software_timer_core.sv
// ----------------------------------------------------------------------------
// multi_channel_software_timer_core
// A bank of countdown timers driven by tick, service and command transactions.
// ----------------------------------------------------------------------------
// A tick or service transaction walks all timers in ascending order; each timer
// gets a period/count memory read, then an update. A create stops at the first
// stopped timer. An addressed command reads its timer, updates it and then
// reports a status; an out-of-range one goes straight to its status. Each
// result waits in an output register, and a receiver that stalls a waiting
// result holds the block. Expiry notices leave in timer order, with last_of_run
// on the final one. The input is ready only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_software_timer_core #(
  parameter int unsigned NUM_TIMERS = mcst_pkg::TimerCountDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  mcst_in_if.sink                            in_i,
  mcst_out_if.source                         out_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mcst_pkg::ApbAddrW-1:0] paddr,
  input  wire logic [mcst_pkg::ApbDataW-1:0] pwdata,
  output logic      [mcst_pkg::ApbDataW-1:0] prdata,
  output logic                               pready
);

  localparam int unsigned IdxW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [IdxW-1:0] TimerLast = IdxW'(NUM_TIMERS - 1);
  localparam int unsigned CntW = mcst_pkg::NoticeCntW;

  mcst_pkg::state_e state_q, state_d;
  mcst_pkg::kind_e  kind_q;
  logic [mcst_pkg::IndexW-1:0]  idx_q;
  logic [mcst_pkg::PeriodW-1:0] per_q;
  logic                         rel_q, ntf_q;

  logic [IdxW-1:0] t_q, t_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pend_valid_q, pend_valid_d;
  logic [IdxW-1:0] pend_slot_q, pend_slot_d;
  logic            st_acc_q, st_acc_d;
  logic [mcst_pkg::IndexW-1:0] st_slot_q, st_slot_d;
  logic            deferred_q;

  mcst_pkg::mode_e  mode_q [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] reload_q, notify_q, pvalid_q;

  logic [mcst_pkg::PeriodW-1:0] per_mem [NUM_TIMERS];
  logic [mcst_pkg::PeriodW-1:0] rem_mem [NUM_TIMERS];
  logic [mcst_pkg::PeriodW-1:0] per_rd_q, rem_rd_q;

  logic                         mode_we, rem_we, per_we, pv_we, flag_we;
  mcst_pkg::mode_e              mode_wd;
  logic [mcst_pkg::PeriodW-1:0] rem_wd, per_wd;
  logic                         pv_wd, rel_wd, ntf_wd;

  logic                         push_en, push_kind, push_acc, push_last;
  logic [mcst_pkg::IndexW-1:0]  push_slot;
  logic                         out_valid_q, out_kind_q, out_acc_q, out_last_q;
  logic [mcst_pkg::IndexW-1:0]  out_slot_q;

  logic                         accept, can_push, in_range, expire, emit, go;
  mcst_pkg::kind_e              in_kind;
  mcst_pkg::mode_e              cur_mode;
  logic [mcst_pkg::PeriodW-1:0] per_rd, dec;
  logic                         cfg_wr;

  assign in_kind  = mcst_pkg::kind_e'(in_i.kind);
  assign accept   = in_i.valid && in_i.ready;
  assign in_range = {1'b0, in_i.timer_index} < 9'(NUM_TIMERS);
  assign can_push = !out_valid_q || out_o.ready;
  assign cur_mode = mode_q[t_q];
  assign per_rd   = pvalid_q[t_q] ? per_rd_q : '0;
  assign dec      = rem_rd_q - 32'd1;

  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[2] == mcst_pkg::REG_DEFERRED);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == mcst_pkg::REG_DEFERRED) ?
                  {{(mcst_pkg::ApbDataW-1){1'b0}}, deferred_q} : '0;

  assign out_o.valid       = out_valid_q;
  assign out_o.result_kind = out_kind_q;
  assign out_o.accepted    = out_acc_q;
  assign out_o.slot        = out_slot_q;
  assign out_o.last_of_run = out_last_q;

  always_comb begin
    state_d      = state_q;
    t_d          = t_q;
    cnt_d        = cnt_q;
    pend_valid_d = pend_valid_q;
    pend_slot_d  = pend_slot_q;
    st_acc_d     = st_acc_q;
    st_slot_d    = st_slot_q;
    in_i.ready   = 1'b0;
    mode_we      = 1'b0;
    mode_wd      = mcst_pkg::MODE_STOPPED;
    rem_we       = 1'b0;
    rem_wd       = '0;
    per_we       = 1'b0;
    per_wd       = per_q;
    pv_we        = 1'b0;
    pv_wd        = 1'b1;
    flag_we      = 1'b0;
    rel_wd       = rel_q;
    ntf_wd       = ntf_q;
    push_en      = 1'b0;
    push_kind    = mcst_pkg::RES_NOTICE;
    push_acc     = 1'b1;
    push_slot    = 8'(pend_slot_q);
    push_last    = 1'b0;
    expire       = 1'b0;
    emit         = 1'b0;
    go           = 1'b1;

    unique case (state_q)
      mcst_pkg::S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          if (in_kind == mcst_pkg::KIND_TICK || in_kind == mcst_pkg::KIND_SERVICE ||
              in_kind == mcst_pkg::KIND_CREATE) begin
            t_d          = '0;
            cnt_d        = '0;
            pend_valid_d = 1'b0;
            state_d      = mcst_pkg::S_READ;
          end else if (!in_range) begin
            st_acc_d  = 1'b0;
            st_slot_d = in_i.timer_index;
            state_d   = mcst_pkg::S_STATUS;
          end else begin
            t_d     = in_i.timer_index[IdxW-1:0];
            state_d = mcst_pkg::S_READ;
          end
        end
      end

      mcst_pkg::S_READ: begin
        state_d = mcst_pkg::S_EXEC;
      end

      mcst_pkg::S_EXEC: begin
        st_slot_d = idx_q;
        state_d   = mcst_pkg::S_STATUS;
        case (kind_q) inside
          mcst_pkg::KIND_TICK, mcst_pkg::KIND_SERVICE: begin
            if (kind_q == mcst_pkg::KIND_TICK && cur_mode == mcst_pkg::MODE_RUNNING) begin
              if (dec != '0) begin
                rem_we = 1'b1;
                rem_wd = dec;
              end else if (deferred_q) begin
                mode_we = 1'b1;
                mode_wd = mcst_pkg::MODE_EXPIRED;
                rem_we  = 1'b1;
              end else begin
                expire = 1'b1;
              end
            end
            if (kind_q == mcst_pkg::KIND_SERVICE && cur_mode == mcst_pkg::MODE_EXPIRED) begin
              expire = 1'b1;
            end
            if (expire) begin
              emit    = notify_q[t_q] && (cnt_q < CntW'(mcst_pkg::MaxNotices));
              mode_we = 1'b1;
              rem_we  = 1'b1;
              if (reload_q[t_q]) begin
                mode_wd = mcst_pkg::MODE_RUNNING;
                rem_wd  = per_rd;
              end
            end
            go = !(emit && pend_valid_q && !can_push);
            if (go) begin
              if (emit) begin
                push_en      = pend_valid_q;
                pend_valid_d = 1'b1;
                pend_slot_d  = t_q;
                cnt_d        = cnt_q + CntW'(1);
              end
              if (t_q == TimerLast) begin
                state_d = mcst_pkg::S_FLUSH;
              end else begin
                t_d     = t_q + IdxW'(1);
                state_d = mcst_pkg::S_READ;
              end
            end else begin
              state_d = mcst_pkg::S_EXEC;
            end
          end
          mcst_pkg::KIND_CREATE: begin
            if (cur_mode == mcst_pkg::MODE_STOPPED) begin
              per_we    = 1'b1;
              pv_we     = 1'b1;
              rem_we    = 1'b1;
              flag_we   = 1'b1;
              st_acc_d  = 1'b1;
              st_slot_d = 8'(t_q);
            end else if (t_q == TimerLast) begin
              st_acc_d  = 1'b0;
              st_slot_d = '0;
            end else begin
              t_d     = t_q + IdxW'(1);
              state_d = mcst_pkg::S_READ;
            end
          end
          mcst_pkg::KIND_START: begin
            st_acc_d = (cur_mode == mcst_pkg::MODE_STOPPED);
            if (cur_mode == mcst_pkg::MODE_STOPPED) begin
              mode_we = 1'b1;
              mode_wd = mcst_pkg::MODE_RUNNING;
              rem_we  = 1'b1;
              rem_wd  = per_rd;
            end
          end
          mcst_pkg::KIND_STOP: begin
            st_acc_d = 1'b1;
            mode_we  = 1'b1;
          end
          mcst_pkg::KIND_RESTART: begin
            st_acc_d = 1'b1;
            mode_we  = 1'b1;
            mode_wd  = mcst_pkg::MODE_RUNNING;
            rem_we   = 1'b1;
            rem_wd   = per_rd;
          end
          mcst_pkg::KIND_DELETE: begin
            st_acc_d = 1'b1;
            mode_we  = 1'b1;
            rem_we   = 1'b1;
            pv_we    = 1'b1;
            pv_wd    = 1'b0;
            flag_we  = 1'b1;
            rel_wd   = 1'b0;
            ntf_wd   = 1'b0;
          end
          default: begin
            st_acc_d = (per_q != '0);
            if (per_q != '0) begin
              per_we = 1'b1;
              pv_we  = 1'b1;
              if (cur_mode == mcst_pkg::MODE_RUNNING) begin
                rem_we = 1'b1;
                rem_wd = per_q;
              end
            end
          end
        endcase
        if (!go) begin
          mode_we = 1'b0;
          rem_we  = 1'b0;
        end
      end

      mcst_pkg::S_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = mcst_pkg::S_IDLE;
        end else if (can_push) begin
          push_en      = 1'b1;
          push_last    = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = mcst_pkg::S_IDLE;
        end
      end

      mcst_pkg::S_STATUS: begin
        if (can_push) begin
          push_en   = 1'b1;
          push_kind = mcst_pkg::RES_STATUS;
          push_acc  = st_acc_q;
          push_slot = st_slot_q;
          push_last = 1'b1;
          state_d   = mcst_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = mcst_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mcst_pkg::S_IDLE;
      t_q          <= '0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      deferred_q   <= 1'b0;
      reload_q     <= '0;
      notify_q     <= '0;
      pvalid_q     <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        mode_q[i] <= mcst_pkg::MODE_STOPPED;
      end
    end else begin
      state_q      <= state_d;
      t_q          <= t_d;
      cnt_q        <= cnt_d;
      pend_valid_q <= pend_valid_d;
      if (cfg_wr) begin
        deferred_q <= pwdata[0];
      end
      if (mode_we) begin
        mode_q[t_q] <= mode_wd;
      end
      if (pv_we) begin
        pvalid_q[t_q] <= pv_wd;
      end
      if (flag_we) begin
        reload_q[t_q] <= rel_wd;
        notify_q[t_q] <= ntf_wd;
      end
      if (push_en) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= in_kind;
      idx_q  <= in_i.timer_index;
      per_q  <= in_i.period_ticks;
      rel_q  <= in_i.reload_on_expiry;
      ntf_q  <= in_i.notify_on_expiry;
    end
    pend_slot_q <= pend_slot_d;
    st_acc_q    <= st_acc_d;
    st_slot_q   <= st_slot_d;
    if (push_en) begin
      out_kind_q <= push_kind;
      out_acc_q  <= push_acc;
      out_slot_q <= push_slot;
      out_last_q <= push_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (per_we) begin
      per_mem[t_q] <= per_wd;
    end
    per_rd_q <= per_mem[t_q];
  end

  always_ff @(posedge clk_i) begin
    if (rem_we) begin
      rem_mem[t_q] <= rem_wd;
    end
    rem_rd_q <= rem_mem[t_q];
  end

endmodule

`default_nettype wire
